### src/tpet_pkg.sv
package tpet_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIRROR_AXES  = 2'd0,
      CSR_LONG_DELAY   = 2'd1,
      CSR_REPEAT_DELAY = 2'd2,
      CSR_REARM        = 2'd3
   } csr_index_type;

   localparam logic [15:0] LONG_DELAY_RESET   = 16'd20;
   localparam logic [15:0] REPEAT_DELAY_RESET = 16'd5;
   localparam logic [15:0] REARM_RESET        = 16'd10;

   typedef enum logic [1:0] {
      EV_DOWN = 2'd0,
      EV_LONG = 2'd1,
      EV_UP   = 2'd2
   } event_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_CONFIRM = 3'd1,
      PH_HELD    = 3'd2,
      PH_REPEAT  = 3'd3,
      PH_REARM   = 3'd4
   } phase_type;

   typedef struct packed {
      logic        pen_down;
      logic [11:0] raw_x;
      logic [11:0] raw_y;
   } req_item_type;

   typedef struct packed {
      event_type   event_kind;
      logic [8:0]  x_pos;
      logic [7:0]  y_pos;
   } rsp_item_type;

   typedef struct packed {
      logic        mirror_axes;
      logic [15:0] long_press_delay;
      logic [15:0] repeat_delay;
      logic [15:0] rearm_interval;
   } csr_type;

   // panel calibration window and screen span per axis
   localparam logic [11:0] X_LO   = 12'd460;
   localparam logic [11:0] X_HI   = 12'd3650;
   localparam logic [8:0]  X_SPAN = 9'd320;
   localparam logic [11:0] Y_LO   = 12'd384;
   localparam logic [11:0] Y_HI   = 12'd3758;
   localparam logic [8:0]  Y_SPAN = 9'd240;

   // divide by (hi - lo) as multiply by ceil(2^32 / (hi - lo)), exact for the value range
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = 21;
   localparam longint unsigned X_DEN = longint'(X_HI) - longint'(X_LO);
   localparam longint unsigned Y_DEN = longint'(Y_HI) - longint'(Y_LO);
   localparam longint unsigned X_RECIP_L = ((64'd1 << RECIP_SHIFT) + X_DEN - 64'd1) / X_DEN;
   localparam longint unsigned Y_RECIP_L = ((64'd1 << RECIP_SHIFT) + Y_DEN - 64'd1) / Y_DEN;
   localparam logic [RECIP_W-1:0] X_RECIP = X_RECIP_L[RECIP_W-1:0];
   localparam logic [RECIP_W-1:0] Y_RECIP = Y_RECIP_L[RECIP_W-1:0];

endpackage

### src/tpet_scale.sv
module tpet_scale
   import tpet_pkg::*;
(
   input  logic         mirror_axes,
   input  req_item_type item,
   output logic [8:0]   x_pos,
   output logic [7:0]   y_pos
);

   localparam int NUM_W  = 21;
   localparam int PROD_W = NUM_W + RECIP_W;

   function automatic logic [9:0] scale_axis(input logic [11:0] v,
                                             input logic [11:0] lo,
                                             input logic [8:0] span,
                                             input logic [RECIP_W-1:0] recip);
      logic [11:0]       d;
      logic [NUM_W-1:0]  n;
      logic [PROD_W-1:0] p;
      logic [9:0]        q;
      d = v - lo;
      n = NUM_W'(d) * NUM_W'(span);
      p = PROD_W'(n) * PROD_W'(recip);
      q = p[RECIP_SHIFT +: 10];
      if (v <= lo || q > 10'(span)) begin
         q = '0;
      end
      return q;
   endfunction

   logic [11:0] vx;
   logic [11:0] vy;
   logic [9:0]  qx;
   logic [9:0]  qy;

   // mirrored reading is 0xfff - v, i.e. the bitwise complement
   assign vx = mirror_axes ? ~item.raw_x : item.raw_x;
   assign vy = mirror_axes ? ~item.raw_y : item.raw_y;

   assign qx = scale_axis(vx, X_LO, X_SPAN, X_RECIP);
   assign qy = scale_axis(vy, Y_LO, Y_SPAN, Y_RECIP);

   assign x_pos = qx[8:0];
   assign y_pos = qy[7:0];

endmodule

### src/tpet_core.sv
module tpet_core
   import tpet_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  csr_type      csr,
   input  logic         in_valid,
   input  logic         pen_down,
   input  logic [8:0]   scaled_x,
   input  logic [7:0]   scaled_y,
   output logic         in_taken,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   input  logic         rsp_stall
);

   phase_type    phase_ff, phase_in;
   logic [15:0]  tick_ff, tick_in;
   logic [8:0]   last_x_ff, last_x_in;
   logic [7:0]   last_y_ff, last_y_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   logic         emit;
   event_type    kind;
   logic [15:0]  limit;
   logic         proc;

   // an item moves on once the result register is free or being drained
   assign proc     = in_valid && (!rsp_valid_ff || !rsp_stall);
   assign in_taken = proc;
   assign limit    = (phase_ff == PH_HELD) ? csr.long_press_delay : csr.repeat_delay;

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      emit      = 1'b0;
      kind      = EV_DOWN;
      if (proc) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (pen_down) begin
                  phase_in = PH_CONFIRM;
               end
            end
            PH_CONFIRM: begin
               if (pen_down) begin
                  last_x_in = scaled_x;
                  last_y_in = scaled_y;
                  phase_in  = PH_HELD;
                  tick_in   = '0;
                  emit      = 1'b1;
                  kind      = EV_DOWN;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_HELD, PH_REPEAT: begin
               if (pen_down) begin
                  if (tick_ff >= limit) begin
                     last_x_in = scaled_x;
                     last_y_in = scaled_y;
                     phase_in  = PH_REPEAT;
                     tick_in   = '0;
                     emit      = 1'b1;
                     kind      = EV_LONG;
                  end else begin
                     tick_in = tick_ff + 16'd1;
                  end
               end else begin
                  // release reports the coordinates held from the last event
                  phase_in = PH_REARM;
                  tick_in  = '0;
                  emit     = 1'b1;
                  kind     = EV_UP;
               end
            end
            PH_REARM: begin
               if (tick_ff < csr.rearm_interval) begin
                  tick_in = tick_ff + 16'd1;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid_in = proc ? emit : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && emit) begin
         rsp_item_ff.event_kind <= kind;
         rsp_item_ff.x_pos      <= last_x_in;
         rsp_item_ff.y_pos      <= last_y_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_confirm_gives_down: assert property (@(posedge clock) disable iff (reset)
      (proc && phase_ff == PH_CONFIRM && pen_down)
      |=> (rsp_valid_ff && rsp_item_ff.event_kind == EV_DOWN && phase_ff == PH_HELD))
      else $error("confirmed press did not produce a down item");

   a_idle_no_result: assert property (@(posedge clock) disable iff (reset)
      (proc && (phase_ff == PH_IDLE || phase_ff == PH_REARM)) |=> !rsp_valid_ff)
      else $error("result produced in idle or rearm phase");

   a_emit_clears_count: assert property (@(posedge clock) disable iff (reset)
      (proc && emit) |=> (tick_ff == 16'd0))
      else $error("tick count not cleared on event");

   a_coord_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_item_ff.x_pos <= 9'(X_SPAN) && rsp_item_ff.y_pos <= 8'(Y_SPAN)))
      else $error("scaled coordinate out of screen range");

   a_up_from_hold: assert property (@(posedge clock) disable iff (reset)
      (proc && emit && kind == EV_UP) |=> (phase_ff == PH_REARM))
      else $error("release did not enter rearm");

endmodule

### src/touch_press_event_tracker_top.sv
// Touch press event tracker.
// Request channel (req_valid, req_stall, req_item): one item per panel tick
// with the pen-down level and raw 12-bit x/y readings. Result channel
// (rsp_valid, rsp_stall, rsp_item): DOWN, LONG or UP events with screen
// coordinates scaled to 0..320 / 0..240. Most ticks produce no result.
// Configuration: csr_wr_en writes csr_wdata into the register picked by
// csr_index (mirror, long-press delay, repeat delay, rearm interval); write
// only while no item is in flight.
// Path: an accepted item waits in the input register, then the phase
// machine and coordinate scaler feed the result register. Throughput: one
// item per cycle while rsp_stall is not holding a pending result; each
// axis is scaled by a multiply by its span and one by its reciprocal.
// When rsp_stall holds a pending result, one more item waits in the input
// register, after which req_stall rises until the result is taken.
// Reset (synchronous, active high) returns the machine to idle, clears the
// tick count and stored coordinates, drops both valid flags and restores
// the register defaults.
module touch_press_event_tracker_top
   import tpet_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_item_type           req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_item_type           rsp_item,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   csr_type      csr_ff, csr_in;
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         in_taken;
   logic         req_accept;
   logic [8:0]   scaled_x;
   logic [7:0]   scaled_y;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIRROR_AXES:  csr_in.mirror_axes      = csr_wdata[0];
            CSR_LONG_DELAY:   csr_in.long_press_delay = csr_wdata[15:0];
            CSR_REPEAT_DELAY: csr_in.repeat_delay     = csr_wdata[15:0];
            CSR_REARM:        csr_in.rearm_interval   = csr_wdata[15:0];
            default:          csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.mirror_axes      <= 1'b0;
         csr_ff.long_press_delay <= LONG_DELAY_RESET;
         csr_ff.repeat_delay     <= REPEAT_DELAY_RESET;
         csr_ff.rearm_interval   <= REARM_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // input register refills in the same cycle its item moves on
   assign req_stall  = in_valid_ff && !in_taken;
   assign req_accept = req_valid && !req_stall;
   assign in_valid_in = req_accept ? 1'b1 : (in_valid_ff && !in_taken);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_item;
      end
   end

   tpet_scale u_scale (
      .mirror_axes (csr_ff.mirror_axes),
      .item        (in_item_ff),
      .x_pos       (scaled_x),
      .y_pos       (scaled_y)
   );

   tpet_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .in_valid  (in_valid_ff),
      .pen_down  (in_item_ff.pen_down),
      .scaled_x  (scaled_x),
      .scaled_y  (scaled_y),
      .in_taken  (in_taken),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .rsp_stall (rsp_stall)
   );

endmodule
